// ----- sv/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for barometric temperature/pressure compensation.
// ----------------------------------------------------------------------------
package btpc_pkg;

   // request payload
   typedef struct packed {
      logic [23:0] temp_adc;
      logic [23:0] press_adc;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [23:0] temperature_q16;
      logic        [24:0] pressure_q8;
   } rsp_type;

   // multiplier stage enables
   typedef struct packed {
      logic en_pp;
      logic en_sum;
   } mul_ctl_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TEMP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_C = 2'd3;

   localparam int TEMP_STAGES = 4;    // stages inside the temperature path
   localparam int PIPE_STAGES = 15;   // total register stages, output included
   localparam int MUL_CHUNK_W = 24;   // slice width of the split multiplier

   localparam logic signed [31:0] TEMP_MAX  = 32'sd8388607;
   localparam logic signed [31:0] TEMP_MIN  = -32'sd8388608;
   localparam logic        [34:0] PRESS_MAX = 35'd33554431;

endpackage

// ----- sv/baro_temp_pressure_compensation_top.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Barometer compensation: raw temperature/pressure in, Q8.16 C and Q17.8 Pa out.
// ----------------------------------------------------------------------------
//
//   channel   ports                              payload
//   -------   --------------------------------   ---------------------------
//   request   req_valid  req_stall  req_data     temp_adc, press_adc
//   response  rsp_valid  rsp_stall  rsp_data     temperature_q16, pressure_q8
//   csr       csr_we  csr_index  csr_wdata       cal_temp, cal_press_a/b/c
//
// One request per cycle when not stalled; the pipeline depth is set by the multiply chain
// (temperature, then Horner in c and p through split multipliers).
// A stage holds while it and all later stages are full under rsp_stall; bubbles
// collapse, so a request is taken while a finished response waits on rsp_stall.
// Reset (synchronous) clears valid bits and calibration registers.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  btpc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output btpc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [btpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [btpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NS = btpc_pkg::PIPE_STAGES;

   // calibration registers
   logic [39:0] cal_temp_ff;
   logic [47:0] cal_press_a_ff;
   logic [47:0] cal_press_b_ff;
   logic [31:0] cal_press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            btpc_pkg::CSR_CAL_TEMP:    cal_temp_ff    <= csr_wdata[39:0];
            btpc_pkg::CSR_CAL_PRESS_A: cal_press_a_ff <= csr_wdata[47:0];
            btpc_pkg::CSR_CAL_PRESS_B: cal_press_b_ff <= csr_wdata[47:0];
            btpc_pkg::CSR_CAL_PRESS_C: cal_press_c_ff <= csr_wdata[31:0];
         endcase
      end
   end

   // pressure coefficients
   logic signed [17:0] p1m, p2m;
   logic signed [7:0]  p3s, p4s, p7s, p8s, p10s, p11s;
   logic signed [16:0] p5s, p6s;
   logic signed [15:0] p9s;

   assign p1m  = 18'($signed(cal_press_a_ff[15:0])) - 18'sd16384;
   assign p2m  = 18'($signed(cal_press_a_ff[31:16])) - 18'sd16384;
   assign p3s  = $signed(cal_press_a_ff[39:32]);
   assign p4s  = $signed(cal_press_a_ff[47:40]);
   assign p5s  = $signed({1'b0, cal_press_b_ff[15:0]});
   assign p6s  = $signed({1'b0, cal_press_b_ff[31:16]});
   assign p7s  = $signed(cal_press_b_ff[39:32]);
   assign p8s  = $signed(cal_press_b_ff[47:40]);
   assign p9s  = $signed(cal_press_c_ff[15:0]);
   assign p10s = $signed(cal_press_c_ff[23:16]);
   assign p11s = $signed(cal_press_c_ff[31:24]);

   // valid bits and stage enables: a stage moves if it or any later stage has room
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         en[i] = !rsp_stall || !(&(v_ff | NS'((1 << i) - 1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NS-1];

   // temperature, stages 0..3
   logic signed [23:0] tq;

   btpc_temp_comp u_temp (
      .clock           (clock),
      .stage_en        (en[btpc_pkg::TEMP_STAGES-1:0]),
      .cal_temp        (cal_temp_ff),
      .temp_adc        (req_data.temp_adc),
      .tq              (tq)
   );

   // side lines for p and c
   logic [23:0]        p_ff [0:10];
   logic signed [23:0] c_ff [4:13];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff[0] <= req_data.press_adc;
      end
      for (int i = 1; i <= 10; i++) begin
         if (en[i]) begin
            p_ff[i] <= p_ff[i-1];
         end
      end
      if (en[4]) begin
         c_ff[4] <= tq;
      end
      for (int i = 5; i <= 13; i++) begin
         if (en[i]) begin
            c_ff[i] <= c_ff[i-1];
         end
      end
   end

   // stage 4: narrow products
   logic signed [33:0] a1_ff, b1_ff, k10_ff, k11_ff;
   // stage 5: first Horner adds, p^2 coefficient
   logic signed [34:0] a2_ff, b2_ff;
   logic signed [55:0] cc_ff;
   // stages 6,7
   logic signed [59:0] a3_ff, b3_ff, a4_ff, b4_ff;
   logic signed [80:0] pc;
   // stages 8,9
   logic signed [80:0] pc8_ff, pc9_ff;
   logic signed [84:0] a5, b5;
   // stage 10
   logic signed [85:0] a6_ff, u_ff;
   // stages 11,12
   logic signed [85:0] a6b_ff, a6c_ff;
   logic signed [110:0] v;
   // stage 13
   logic signed [111:0] s_ff;

   logic signed [24:0] p4w, p10w;
   assign p4w  = $signed({1'b0, p_ff[3]});
   assign p10w = $signed({1'b0, p_ff[10]});

   logic signed [24:0] p5w, c7w;
   assign p5w = $signed({1'b0, p_ff[5]});
   assign c7w = 25'(c_ff[7]);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         a1_ff  <= p8s * tq;
         b1_ff  <= p4s * tq;
         k10_ff <= p10s * tq;
         k11_ff <= p11s * p4w;
      end
      if (en[5]) begin
         a2_ff <= 35'(a1_ff) + (35'(p7s) <<< 23);
         b2_ff <= 35'(b1_ff) + (35'(p3s) <<< 21);
         cc_ff <= (56'(p9s) <<< 37) + (56'(k10_ff) <<< 21) + (56'(k11_ff) <<< 20);
      end
      if (en[6]) begin
         a3_ff <= a2_ff * c_ff[5];
         b3_ff <= b2_ff * c_ff[5];
      end
      if (en[7]) begin
         a4_ff <= a3_ff + (60'(p6s) <<< 41);
         b4_ff <= b3_ff + (60'(p2m) <<< 40);
      end
      if (en[8]) begin
         pc8_ff <= pc;
      end
      if (en[9]) begin
         pc9_ff <= pc8_ff;
      end
      if (en[10]) begin
         a6_ff <= 86'(a5) + (86'(p5s) <<< 66);
         u_ff  <= 86'(b5) + (86'(p1m) <<< 65) + 86'(pc9_ff);
      end
      if (en[11]) begin
         a6b_ff <= a6_ff;
      end
      if (en[12]) begin
         a6c_ff <= a6b_ff;
      end
      if (en[13]) begin
         s_ff <= (112'(a6c_ff) <<< 22) + 112'(v);
      end
   end

   // C * p, stages 6,7
   btpc_mul_split #(.AW(56), .BW(25)) u_mul_cp (
      .clock (clock),
      .ctl   ('{en_pp: en[6], en_sum: en[7]}),
      .a     (cc_ff),
      .b     (p5w),
      .y     (pc)
   );

   // Horner steps by c, stages 8,9
   btpc_mul_split #(.AW(60), .BW(25)) u_mul_a (
      .clock (clock),
      .ctl   ('{en_pp: en[8], en_sum: en[9]}),
      .a     (a4_ff),
      .b     (c7w),
      .y     (a5)
   );

   btpc_mul_split #(.AW(60), .BW(25)) u_mul_b (
      .clock (clock),
      .ctl   ('{en_pp: en[8], en_sum: en[9]}),
      .a     (b4_ff),
      .b     (c7w),
      .y     (b5)
   );

   // (B + p*C) * p, stages 11,12
   btpc_mul_split #(.AW(86), .BW(25)) u_mul_up (
      .clock (clock),
      .ctl   ('{en_pp: en[11], en_sum: en[12]}),
      .a     (u_ff),
      .b     (p10w),
      .y     (v)
   );

   // stage 14: pressure*2^85 floored to Q17.8, clamped to 0 and the max
   logic [34:0]       hi;
   btpc_pkg::rsp_type rsp_in;
   btpc_pkg::rsp_type rsp_ff;

   always_comb begin
      hi = s_ff[111:77];
      rsp_in.temperature_q16 = c_ff[13];
      if (s_ff[111]) begin
         rsp_in.pressure_q8 = '0;
      end else if (hi > btpc_pkg::PRESS_MAX) begin
         rsp_in.pressure_q8 = btpc_pkg::PRESS_MAX[24:0];
      end else begin
         rsp_in.pressure_q8 = hi[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- sv/btpc_mul_split.sv -----
// ----------------------------------------------------------------------------
// btpc_mul_split
// Wide signed by narrow signed multiply: slice partial products, then sum.
// ----------------------------------------------------------------------------
module btpc_mul_split #(
   parameter int AW = 60,
   parameter int BW = 25
) (
   input  logic                        clock,
   input  btpc_pkg::mul_ctl_type       ctl,
   input  logic signed [AW-1:0]        a,
   input  logic signed [BW-1:0]        b,
   output logic signed [AW+BW-1:0]     y
);

   localparam int CW = btpc_pkg::MUL_CHUNK_W;
   localparam int NC = (AW + CW - 1) / CW;
   localparam int TW = AW - CW * (NC - 1);
   localparam int PW = CW + 1 + BW;
   localparam int RW = AW + BW;

   logic signed [PW-1:0] pp_ff [NC];
   logic signed [RW-1:0] acc;
   logic signed [RW-1:0] y_ff;

   genvar k;
   generate
      for (k = 0; k < NC; k++) begin : g_slice
         logic signed [CW:0] op;
         if (k < NC - 1) begin : g_low
            assign op = $signed({1'b0, a[CW*k +: CW]});
         end else begin : g_top
            assign op = $signed({{(CW + 1 - TW){a[AW-1]}}, a[AW-1 -: TW]});
         end
         always_ff @(posedge clock) begin
            if (ctl.en_pp) begin
               pp_ff[k] <= op * b;
            end
         end
      end
   endgenerate

   always_comb begin
      acc = '0;
      for (int i = 0; i < NC; i++) begin
         acc = acc + (RW'(pp_ff[i]) <<< (CW * i));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_sum) begin
         y_ff <= acc;
      end
   end

   assign y = y_ff;

endmodule

// ----- sv/btpc_temp_comp.sv -----
// ----------------------------------------------------------------------------
// btpc_temp_comp
// Temperature polynomial, four stages, floored and saturated to Q8.16.
// ----------------------------------------------------------------------------
module btpc_temp_comp (
   input  logic                                  clock,
   input  logic [btpc_pkg::TEMP_STAGES-1:0]      stage_en,
   input  logic [39:0]                           cal_temp,
   input  logic [23:0]                           temp_adc,
   output logic signed [23:0]                    tq
);

   logic signed [16:0] t2s;
   logic signed [7:0]  t3s;

   logic signed [25:0] d_ff;
   logic signed [42:0] m1_ff;
   logic signed [42:0] m1b_ff;
   logic signed [51:0] dd_ff;
   logic signed [59:0] y_ff;
   logic signed [23:0] tq_ff;

   logic signed [63:0] x;
   logic signed [31:0] xh;
   logic signed [23:0] tq_in;

   assign t2s = $signed({1'b0, cal_temp[31:16]});
   assign t3s = $signed(cal_temp[39:32]);

   // d*T2*2^18 + d^2*T3, then floor by 2^32
   always_comb begin
      x  = (64'(m1b_ff) <<< 18) + 64'(y_ff);
      xh = x[63:32];
      if (xh > btpc_pkg::TEMP_MAX) begin
         tq_in = btpc_pkg::TEMP_MAX[23:0];
      end else if (xh < btpc_pkg::TEMP_MIN) begin
         tq_in = btpc_pkg::TEMP_MIN[23:0];
      end else begin
         tq_in = xh[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff <= $signed({2'b00, temp_adc}) - $signed({2'b00, cal_temp[15:0], 8'h00});
      end
      if (stage_en[1]) begin
         m1_ff <= d_ff * t2s;
         dd_ff <= d_ff * d_ff;
      end
      if (stage_en[2]) begin
         y_ff   <= dd_ff * t3s;
         m1b_ff <= m1_ff;
      end
      if (stage_en[3]) begin
         tq_ff <= tq_in;
      end
   end

   assign tq = tq_ff;

endmodule
